### hdl/aabb_xf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aabb_xf_pkg
// shared constants, register codes and pipeline control types for the
// box transform unit
// ----------------------------------------------------------------------------
package aabb_xf_pkg;

	// default number formats
	localparam int COORD_WIDTH_DEF = 24;
	localparam int COEF_WIDTH_DEF  = 16;

	// configuration register map
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_Y   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_Z   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Z = 3'd5;

	// load enables of the three pipeline stages
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} stage_en_t;

endpackage
`default_nettype wire

### hdl/aabb_xf_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aabb_xf_cfg
// matrix rows and translation registers, written over the config channel
// ----------------------------------------------------------------------------
module aabb_xf_cfg
	import aabb_xf_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int COEF_WIDTH  = COEF_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wr_en,
	input  wire logic [CFG_IDX_W-1:0]          wr_index,
	input  wire logic [3*COEF_WIDTH-1:0]       wr_data,
	output logic        [3*COEF_WIDTH-1:0]     row_q   [3],
	output logic signed [COORD_WIDTH-1:0]      shift_q [3]
);

	// unity coefficient, placed on the diagonal at reset
	localparam logic [COEF_WIDTH-1:0] COEF_ONE =
		{1'b0, 1'b1, {(COEF_WIDTH-2){1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0]   <= {{(2*COEF_WIDTH){1'b0}}, COEF_ONE};
			row_q[1]   <= {{COEF_WIDTH{1'b0}}, COEF_ONE, {COEF_WIDTH{1'b0}}};
			row_q[2]   <= {COEF_ONE, {(2*COEF_WIDTH){1'b0}}};
			shift_q[0] <= '0;
			shift_q[1] <= '0;
			shift_q[2] <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_ROW_X:   row_q[0]   <= wr_data;
				REG_ROW_Y:   row_q[1]   <= wr_data;
				REG_ROW_Z:   row_q[2]   <= wr_data;
				REG_SHIFT_X: shift_q[0] <= wr_data[COORD_WIDTH-1:0];
				REG_SHIFT_Y: shift_q[1] <= wr_data[COORD_WIDTH-1:0];
				REG_SHIFT_Z: shift_q[2] <= wr_data[COORD_WIDTH-1:0];
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

### hdl/aabb_xf_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aabb_xf_lane
// one output axis: products, row sums with rounding, shift and saturation
// ----------------------------------------------------------------------------
module aabb_xf_lane
	import aabb_xf_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int COEF_WIDTH  = COEF_WIDTH_DEF
) (
	input  wire logic                            clk,
	input  wire stage_en_t                       en,
	input  wire logic [3*COEF_WIDTH-1:0]         coef_row,
	input  wire logic signed [COORD_WIDTH-1:0]   shift,
	input  wire logic [3*COORD_WIDTH-1:0]        centers,
	input  wire logic [3*(COORD_WIDTH-1)-1:0]    halves,
	output logic signed [COORD_WIDTH-1:0]        new_center,
	output logic [COORD_WIDTH-2:0]               new_half
);

	localparam int FRAC = COEF_WIDTH - 2;
	localparam int PW   = COEF_WIDTH + COORD_WIDTH;      // centre product
	localparam int HPW  = COEF_WIDTH + COORD_WIDTH - 1;  // half product
	localparam int SW   = PW + 2;
	localparam int HSW  = HPW + 2;
	localparam int RW   = SW - FRAC;                     // rounded centre sum
	localparam int HRW  = HSW - FRAC;                    // rounded half sum

	localparam logic signed [SW-1:0] C_RND = {{(SW-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};
	localparam logic [HSW-1:0]       H_RND = {{(HSW-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};
	localparam logic signed [RW:0]   C_MAX = {{(RW+2-COORD_WIDTH){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [RW:0]   C_MIN = {{(RW+2-COORD_WIDTH){1'b1}}, {(COORD_WIDTH-1){1'b0}}};
	localparam logic [HRW-1:0]       H_MAX = {{(HRW+1-COORD_WIDTH){1'b0}}, {(COORD_WIDTH-1){1'b1}}};

	logic signed [COEF_WIDTH-1:0]  m   [3];
	logic        [COEF_WIDTH-1:0]  am  [3];
	logic signed [COORD_WIDTH-1:0] c   [3];
	logic        [COORD_WIDTH-2:0] h   [3];

	logic signed [PW-1:0]  cprod_s1 [3];
	logic        [HPW-1:0] hprod_s1 [3];
	logic signed [SW-1:0]  csum_s2;
	logic        [HSW-1:0] hsum_s2;

	logic signed [RW:0]    cshift;
	logic        [HRW-1:0] hround;

	// operand split; |m| of the most negative code fits unsigned
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			m[k]  = coef_row[k*COEF_WIDTH +: COEF_WIDTH];
			am[k] = m[k][COEF_WIDTH-1] ? (~m[k] + 1'b1) : m[k];
			c[k]  = centers[k*COORD_WIDTH +: COORD_WIDTH];
			h[k]  = halves[k*(COORD_WIDTH-1) +: (COORD_WIDTH-1)];
		end
	end

	// stage 1: products
	always_ff @(posedge clk) begin
		if (en.s1) begin
			for (int k = 0; k < 3; k++) begin
				cprod_s1[k] <= m[k] * c[k];
				hprod_s1[k] <= am[k] * h[k];
			end
		end
	end

	// stage 2: row sums plus half an lsb
	always_ff @(posedge clk) begin
		if (en.s2) begin
			csum_s2 <= SW'(cprod_s1[0]) + SW'(cprod_s1[1]) + SW'(cprod_s1[2]) + C_RND;
			hsum_s2 <= HSW'(hprod_s1[0]) + HSW'(hprod_s1[1]) + HSW'(hprod_s1[2]) + H_RND;
		end
	end

	// floor by dropping fraction bits, then translate
	always_comb begin
		cshift = $signed({csum_s2[SW-1], csum_s2[SW-1:FRAC]})
			+ $signed({{(RW+1-COORD_WIDTH){shift[COORD_WIDTH-1]}}, shift});
		hround = hsum_s2[HSW-1:FRAC];
	end

	// stage 3: saturation
	always_ff @(posedge clk) begin
		if (en.s3) begin
			if (cshift > C_MAX)
				new_center <= C_MAX[COORD_WIDTH-1:0];
			else if (cshift < C_MIN)
				new_center <= C_MIN[COORD_WIDTH-1:0];
			else
				new_center <= cshift[COORD_WIDTH-1:0];
			if (hround > H_MAX)
				new_half <= H_MAX[COORD_WIDTH-2:0];
			else
				new_half <= hround[COORD_WIDTH-2:0];
		end
	end

endmodule
`default_nettype wire

### hdl/aabb_affine_transform_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aabb_affine_transform_unit
// encloses an axis-aligned box after an affine transform
// ----------------------------------------------------------------------------
// One box beat (signed centre and unsigned half sizes, 8 fraction bits) comes
// in on the s_ side and one transformed box leaves on the m_ side. The new
// centre is the configured matrix times the centre plus the translation; each
// new half size is the dot product of the absolute coefficients of one matrix
// row with the half sizes. Sums are rounded to nearest with ties upward and
// saturated to the coordinate range (half sizes to zero and above). The unit
// takes one box per clock while s_tready is high and passes it through three
// register stages: multiply (eighteen multipliers of coefficient by
// coordinate), three-way row sum, and round, translate and saturate. The
// last stage is the output register, so a stalled output does not stop
// input until all three stages hold a box. Configuration writes are always
// accepted without back-pressure and must only be made while no box is in
// flight; matrix rows reset to identity, translation to zero.
// ----------------------------------------------------------------------------
module aabb_affine_transform_unit
	import aabb_xf_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int COEF_WIDTH  = COEF_WIDTH_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// box in
	input  wire logic                                  s_tvalid,
	output logic                                       s_tready,
	// center_x, center_y, center_z, half_x, half_y, half_z, zero pad
	input  wire logic [((6*COORD_WIDTH+4)/8)*8-1:0]    s_tdata,
	// box out
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	// new_center_x, new_center_y, new_center_z, new_half_x, new_half_y,
	// new_half_z, zero pad
	output logic [((6*COORD_WIDTH+4)/8)*8-1:0]         m_tdata,
	// register writes
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]                  cfg_index,
	input  wire logic [3*COEF_WIDTH-1:0]               cfg_data
);

	localparam int DATA_W = ((6*COORD_WIDTH+4)/8)*8;
	localparam int BOX_W  = 6*COORD_WIDTH - 3;
	localparam int HOFF   = 3*COORD_WIDTH;   // half sizes start here

	logic        [3*COEF_WIDTH-1:0] row   [3];
	logic signed [COORD_WIDTH-1:0]  shift [3];

	logic signed [COORD_WIDTH-1:0]  new_center [3];
	logic        [COORD_WIDTH-2:0]  new_half   [3];

	logic      valid_s1, valid_s2, valid_s3;
	logic      ready_s1, ready_s2, ready_s3;
	stage_en_t stage_en;

	// register file; never back-pressures
	assign cfg_ready = 1'b1;

	aabb_xf_cfg #(
		.COORD_WIDTH (COORD_WIDTH),
		.COEF_WIDTH  (COEF_WIDTH)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.row_q    (row),
		.shift_q  (shift)
	);

	// a stage loads when it is empty or its content moves on in this cycle
	assign ready_s3 = !valid_s3 || m_tready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign s_tready = ready_s1;

	assign stage_en.s1 = ready_s1;
	assign stage_en.s2 = ready_s2;
	assign stage_en.s3 = ready_s3;

	// valid bits travel alongside the lane data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1)
				valid_s1 <= s_tvalid;
			if (ready_s2)
				valid_s2 <= valid_s1;
			if (ready_s3)
				valid_s3 <= valid_s2;
		end
	end

	assign m_tvalid = valid_s3;

	// one lane per output axis, each reading its own matrix row
	for (genvar r = 0; r < 3; r++) begin : g_lane
		aabb_xf_lane #(
			.COORD_WIDTH (COORD_WIDTH),
			.COEF_WIDTH  (COEF_WIDTH)
		) u_lane (
			.clk        (clk),
			.en         (stage_en),
			.coef_row   (row[r]),
			.shift      (shift[r]),
			.centers    (s_tdata[HOFF-1:0]),
			.halves     (s_tdata[BOX_W-1:HOFF]),
			.new_center (new_center[r]),
			.new_half   (new_half[r])
		);
	end

	assign m_tdata = {{(DATA_W-BOX_W){1'b0}},
		new_half[2], new_half[1], new_half[0],
		new_center[2], new_center[1], new_center[0]};

`ifndef SYNTHESIS
	// a free output always frees the input
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output was free");

	// an accepted beat lands in the first stage
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> valid_s1)
		else $error("accepted beat lost at stage 1");

	// a box moving out of stage 2 reaches the output register
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && ready_s3) |=> valid_s3)
		else $error("box lost between stage 2 and 3");

	// with all stages full and the output held, no new beat is taken
	a_full_block: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && valid_s3 && !m_tready) |-> !s_tready)
		else $error("input taken into a full pipeline");
`endif

endmodule
`default_nettype wire

### verif/aabb_affine_transform_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_affine_transform_unit_tb
// self-checking bench for the box transform unit
// ----------------------------------------------------------------------------
// Boxes go in on the s_ stream and every one is run through a local model of
// the transform: matrix times centre plus translation, and abs(row) dot half
// sizes. Both sums are rounded to nearest with ties upward and then clamped
// to the coordinate range. The model's expectation is queued when the beat
// is accepted, and each m_ beat is checked field by field against the
// oldest entry. Both stream sides idle at random. Register writes are made
// only once the unit has drained. A directed set covers the extremes,
// rounding ties and the spare register indexes. Random phases under fresh
// register settings follow.
// ----------------------------------------------------------------------------
module aabb_affine_transform_unit_tb;
	import aabb_xf_pkg::*;

	localparam int CW      = COORD_WIDTH_DEF;
	localparam int KW      = COEF_WIDTH_DEF;
	localparam int BUS_W   = ((6*CW+4)/8)*8;
	localparam int PAD_W   = BUS_W - (6*CW-3);
	localparam int FRAC    = KW - 2;
	localparam longint HALF_LSB = longint'(1) << (FRAC - 1);
	localparam longint CMAX     = (longint'(1) << (CW - 1)) - 1;
	localparam longint CMIN     = -(longint'(1) << (CW - 1));
	localparam int PHASES       = 8;
	localparam int PHASE_BOXES  = 240;
	localparam int MAX_PRINTS   = 200;

	// indexes past the register map, writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	// same layout as s_tdata and m_tdata, centre[0] in the lowest bits
	typedef struct packed {
		logic [PAD_W-1:0]       pad;
		logic [2:0][CW-2:0]     half;
		logic [2:0][CW-1:0]     centre;
	} box_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	// center_x, center_y, center_z, half_x, half_y, half_z, zero pad
	logic [BUS_W-1:0]       s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	// new_center_x, new_center_y, new_center_z, new_half_x, new_half_y,
	// new_half_z, zero pad
	logic [BUS_W-1:0]       m_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [3*KW-1:0]        cfg_data = '0;

	// shadow copy of the register file, reset values as in the unit
	logic [3*KW-1:0]        coef_rows [3];
	logic signed [CW-1:0]   shifts [3];

	box_t                   pending_boxes [$];
	int                     errors = 0;
	int                     boxes_sent = 0;
	int                     boxes_checked = 0;
	int                     reg_writes = 0;
	int                     setups = 0;
	int                     send_calm = 0;
	int                     recv_calm = 0;

	aabb_affine_transform_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// model of the transform
	// ------------------------------------------------------------------------
	function automatic box_t transform_box(box_t b);
		box_t   res;
		longint m, c, h, cs, hs, nc, nh;
		int     r, k;
		res = '0;
		for (r = 0; r < 3; r++) begin
			cs = 0;
			hs = 0;
			for (k = 0; k < 3; k++) begin
				m = longint'($signed(coef_rows[r][k*KW +: KW]));
				c = longint'($signed(b.centre[k]));
				h = longint'(b.half[k]);
				cs += m * c;
				// most negative coefficient keeps its full magnitude
				hs += (m < 0 ? -m : m) * h;
			end
			// round to nearest, ties upward, translation after rounding
			nc = ((cs + HALF_LSB) >>> FRAC) + longint'(shifts[r]);
			nh = (hs + HALF_LSB) >>> FRAC;
			if (nc > CMAX) nc = CMAX;
			else if (nc < CMIN) nc = CMIN;
			if (nh > CMAX) nh = CMAX;
			else if (nh < 0) nh = 0;
			res.centre[r] = nc[CW-1:0];
			res.half[r]   = nh[CW-2:0];
		end
		return res;
	endfunction

	function automatic box_t make_box(int cx, int cy, int cz, int hx, int hy, int hz);
		box_t b;
		b = '0;
		b.centre[0] = cx[CW-1:0];
		b.centre[1] = cy[CW-1:0];
		b.centre[2] = cz[CW-1:0];
		b.half[0]   = hx[CW-2:0];
		b.half[1]   = hy[CW-2:0];
		b.half[2]   = hz[CW-2:0];
		return b;
	endfunction

	// idle cycles before a beat, with occasional calm stretches of none
	function automatic int pick_gap(inout int calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 29) == 0) calm_left = $urandom_range(10, 60);
		return $urandom_range(0, 13);
	endfunction

	// ------------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------------
	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (errors < MAX_PRINTS)
			$display("mismatch on box %0d, %s: got %0h, expected %0h",
				boxes_checked, what, got, want);
		errors++;
	endtask

	task automatic check_box(input box_t got);
		box_t want;
		int   k;
		if (pending_boxes.size() == 0) begin
			report_mismatch("beat with no box outstanding", got.centre[0], 0);
		end else begin
			want = pending_boxes.pop_front();
			for (k = 0; k < 3; k++) begin
				if (got.centre[k] !== want.centre[k])
					report_mismatch($sformatf("new_center[%0d]", k),
						got.centre[k], want.centre[k]);
				if (got.half[k] !== want.half[k])
					report_mismatch($sformatf("new_half[%0d]", k),
						got.half[k], want.half[k]);
			end
			if (got.pad !== '0) report_mismatch("pad bits", got.pad, 0);
		end
		boxes_checked++;
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) check_box(box_t'(m_tdata));
	end

	// output side: random stall before taking each beat
	initial begin : result_sink
		int stall;
		wait (arst_n);
		forever begin
			stall = pick_gap(recv_calm);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// ------------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------------
	// valid is only lowered for a gap, so back-to-back beats stay high
	task automatic push_box(input box_t b);
		int gap;
		gap = pick_gap(send_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		pending_boxes.push_back(transform_box(b));
		boxes_sent++;
	endtask

	// wait until every box has left, then past the three pipeline stages
	task automatic settle_unit();
		s_tvalid <= 1'b0;
		while (pending_boxes.size() != 0) @(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [3*KW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_ROW_X:   coef_rows[0] = data;
			REG_ROW_Y:   coef_rows[1] = data;
			REG_ROW_Z:   coef_rows[2] = data;
			REG_SHIFT_X: shifts[0] = data[CW-1:0];
			REG_SHIFT_Y: shifts[1] = data[CW-1:0];
			REG_SHIFT_Z: shifts[2] = data[CW-1:0];
			default: ;
		endcase
		reg_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// translation with junk above the register width
	function automatic logic [3*KW-1:0] junk_shift(int value);
		logic [3*KW-1:0] d;
		d = {$urandom, $urandom};
		d[CW-1:0] = value[CW-1:0];
		return d;
	endfunction

	function automatic logic [KW-1:0] pick_coef();
		case ($urandom_range(0, 7))
			0: return {1'b1, {(KW-1){1'b0}}};
			1: return {1'b0, {(KW-1){1'b1}}};
			2: return '0;
			3, 4, 5: return KW'($urandom_range(0, 2 << FRAC) - (1 << FRAC));
			default: return KW'($urandom);
		endcase
	endfunction

	function automatic logic [3*KW-1:0] random_row();
		return {pick_coef(), pick_coef(), pick_coef()};
	endfunction

	function automatic int random_shift();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? int'(CMAX) : int'(CMIN);
			default: return $urandom_range(0, 1 << 13) - (1 << 12);
		endcase
	endfunction

	function automatic box_t random_box();
		box_t b;
		int   k;
		b = '0;
		for (k = 0; k < 3; k++) begin
			case ($urandom_range(0, 7))
				0: b.centre[k] = $urandom_range(0, 1) ? CW'(CMAX) : CW'(CMIN);
				1, 2, 3: b.centre[k] = CW'($urandom);
				default: b.centre[k] = CW'($urandom_range(0, 1 << 17) - (1 << 16));
			endcase
			case ($urandom_range(0, 7))
				0: b.half[k] = $urandom_range(0, 1) ? '1 : '0;
				1, 2, 3: b.half[k] = (CW-1)'($urandom);
				default: b.half[k] = (CW-1)'($urandom_range(0, 1 << 16));
			endcase
		end
		return b;
	endfunction

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------
	// reset setup is identity with no translation, so boxes pass unchanged
	task automatic test_identity_passthrough();
		push_box(make_box(int'(CMAX), int'(CMIN), 0, int'(CMAX), 0, 1));
		push_box(make_box(-1, 1, 'h123456, 0, int'(CMAX), 'h55555));
		push_box(make_box(0, 0, 0, 0, 0, 0));
		setups++;
	endtask

	// every index once, spare indexes with junk, upper bits of shifts ignored
	task automatic test_register_map();
		settle_unit();
		write_register(REG_ROW_X, {16'h0000, 16'h2000, 16'h4000});
		write_register(REG_ROW_Y, {16'hC000, 16'h4000, 16'h0000});
		write_register(REG_ROW_Z, {16'h4000, 16'h0000, 16'hE000});
		write_register(REG_SHIFT_X, junk_shift(256));
		write_register(REG_SHIFT_Y, junk_shift(-512));
		write_register(REG_SHIFT_Z, junk_shift(1000));
		write_register(REG_SPARE_LO, '1);
		write_register(REG_SPARE_HI, {$urandom, $urandom});
		push_box(make_box(1000, -2000, 3000, 40, 50, 60));
		push_box(make_box(-77777, 12345, -1, 'h1234, 0, 'h7777));
		setups++;
	endtask

	// most negative and most positive coefficients with clamped centres
	task automatic test_extreme_setup();
		settle_unit();
		write_register(REG_ROW_X, {3{1'b1, {(KW-1){1'b0}}}});
		write_register(REG_ROW_Y, {3{1'b0, {(KW-1){1'b1}}}});
		write_register(REG_ROW_Z, '0);
		write_register(REG_SHIFT_X, junk_shift(int'(CMAX)));
		write_register(REG_SHIFT_Y, junk_shift(int'(CMIN)));
		write_register(REG_SHIFT_Z, junk_shift(int'(CMIN)));
		push_box(make_box(int'(CMAX), int'(CMAX), int'(CMAX),
			int'(CMAX), int'(CMAX), int'(CMAX)));
		push_box(make_box(int'(CMIN), int'(CMIN), int'(CMIN), 0, 0, 0));
		push_box(make_box(0, 0, 0, 1, 1, 1));
		push_box(make_box(int'(CMIN), 0, 0, 0, 0, int'(CMAX)));
		push_box(make_box(1, -1, 1, 'h2aaaaa, 'h555555, 3));
		setups++;
	endtask

	// half and one and a half scale, exact ties in both directions
	task automatic test_rounding_ties();
		settle_unit();
		write_register(REG_ROW_X, {16'h0000, 16'h0000, 16'h2000});
		write_register(REG_ROW_Y, {16'h0000, 16'h0000, 16'hE000});
		write_register(REG_ROW_Z, {16'h0000, 16'h6000, 16'h0000});
		write_register(REG_SHIFT_X, '0);
		write_register(REG_SHIFT_Y, '0);
		write_register(REG_SHIFT_Z, '0);
		push_box(make_box(1, 0, 0, 1, 1, 0));
		push_box(make_box(-1, 1, 0, 3, 0, 0));
		push_box(make_box(3, -1, 0, 0, 1, 0));
		push_box(make_box(-3, -3, 0, 5, 3, 0));
		push_box(make_box(0, 3, 0, 0, 5, 0));
		setups++;
	endtask

	// fresh random setup per phase, boxes with random content
	task automatic test_random_boxes();
		int p, n;
		for (p = 0; p < PHASES; p++) begin
			settle_unit();
			write_register(REG_ROW_X, random_row());
			write_register(REG_ROW_Y, random_row());
			write_register(REG_ROW_Z, random_row());
			write_register(REG_SHIFT_X, junk_shift(random_shift()));
			write_register(REG_SHIFT_Y, junk_shift(random_shift()));
			write_register(REG_SHIFT_Z, junk_shift(random_shift()));
			if ($urandom_range(0, 2) == 0)
				write_register($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
					{$urandom, $urandom});
			setups++;
			for (n = 0; n < PHASE_BOXES; n++) push_box(random_box());
		end
	endtask

	// ------------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------------
	initial begin : main_sequence
		coef_rows[0] = {16'h0000, 16'h0000, 16'h4000};
		coef_rows[1] = {16'h0000, 16'h4000, 16'h0000};
		coef_rows[2] = {16'h4000, 16'h0000, 16'h0000};
		shifts[0] = '0;
		shifts[1] = '0;
		shifts[2] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_identity_passthrough();
		test_register_map();
		test_extreme_setup();
		test_rounding_ties();
		test_random_boxes();

		settle_unit();
		repeat (10) @(posedge clk);
		$display("checked %0d of %0d boxes under %0d register setups, %0d register writes",
			boxes_checked, boxes_sent, setups, reg_writes);
		$display("extreme coefficients, saturation, rounding ties and spare indexes included");
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// guard against a hung handshake
	initial begin : watchdog
		#5_000_000;
		$display("timeout with %0d boxes outstanding", pending_boxes.size());
		$display("DONE: errors detected");
		$finish;
	end

endmodule

### aabb_affine_transform_unit.f
hdl/aabb_xf_pkg.sv
hdl/aabb_xf_cfg.sv
hdl/aabb_xf_lane.sv
hdl/aabb_affine_transform_unit.sv
verif/aabb_affine_transform_unit_tb.sv
